>>> hdl/bank_mapper_with_scanline_irq_defines.svh
// Assertion macros shared by the bank mapper RTL.
// Included by the modules that carry concurrent assertions; needs nothing else.
`ifndef BANK_MAPPER_WITH_SCANLINE_IRQ_DEFINES_SVH
`define BANK_MAPPER_WITH_SCANLINE_IRQ_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define BMSI_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define BMSI_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hdl/bmsi_pkg.sv
// Types, codes and helpers of the bank mapper with scanline IRQ.
// Used by every module of the block.
package bmsi_pkg;

    // Request operation codes
    localparam logic [1:0] OP_WRITE = 2'd0;
    localparam logic [1:0] OP_TICK  = 2'd1;
    localparam logic [1:0] OP_RESET = 2'd2;

    // Result kinds
    localparam logic [1:0] KIND_STATUS = 2'd0;
    localparam logic [1:0] KIND_PRG    = 2'd1;
    localparam logic [1:0] KIND_CHR    = 2'd2;
    localparam logic [1:0] KIND_MIRROR = 2'd3;

    // Bus write decode
    localparam logic [15:0] ADDR_MASK      = 16'hF003;
    localparam logic [3:0]  PAGE_PRG01     = 4'h8;
    localparam logic [3:0]  PAGE_PRG2      = 4'h9;
    localparam logic [3:0]  PAGE_CHR_FIRST = 4'hA;
    localparam logic [3:0]  PAGE_CHR_LAST  = 4'hD;
    localparam logic [3:0]  PAGE_IRQ_LATCH = 4'hE;
    localparam logic [3:0]  PAGE_IRQ_CTRL  = 4'hF;
    localparam logic [1:0]  CTRL_RELOAD    = 2'd0;
    localparam logic [1:0]  CTRL_ENABLE    = 2'd1;
    localparam logic [1:0]  CTRL_MIRROR    = 2'd2;

    // Bank slots
    localparam int          PRG_SLOTS     = 3;
    localparam int          CHR_SLOTS     = 8;
    localparam logic [1:0]  PRG_SLOT_LAST = 2'd3;

    // Configuration registers
    localparam logic        REG_PRG_COUNT   = 1'b0;
    localparam logic [8:0]  PRG_COUNT_RESET = 9'd32;

    // One queued job: a single result, or a mapper reset that expands to four
    typedef struct packed {
        logic [1:0] kind;
        logic [2:0] slot;
        logic [7:0] value;
        logic       irq;
        logic       reset_seq;
    } t_job;

    function automatic logic [7:0] set_nibble(logic [7:0] old, logic hi, logic [3:0] v);
        logic [7:0] res;
        res = hi ? {v, old[3:0]} : {old[7:4], v};
        return res;
    endfunction

endpackage

>>> hdl/bmsi_if.sv
// Valid/ready channel interfaces of the bank mapper: request in, result out.
// Depends on nothing but the widths of the mapper's fields.
interface bmsi_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  op;
    logic [15:0] addr;
    logic [7:0]  wdata;

    modport source (output valid, output op, output addr, output wdata, input ready);
    modport sink   (input valid, input op, input addr, input wdata, output ready);
endinterface

interface bmsi_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] kind;
    logic [2:0] slot;
    logic [7:0] value;
    logic       irq_line;
    logic       last;

    modport source (output valid, output kind, output slot, output value,
                    output irq_line, output last, input ready);
    modport sink   (input valid, input kind, input slot, input value,
                    input irq_line, input last, output ready);
endinterface

>>> hdl/bmsi_front.sv
// Front end: decodes each accepted request, updates bank and IRQ state, emits a job.
// Depends on bmsi_pkg.
module bmsi_front #(
    parameter int CYCLES_PER_LINE = 113
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_accept,
    input  logic [1:0]     i_op,
    input  logic [15:0]    i_addr,
    input  logic [7:0]     i_wdata,
    input  logic [7:0]     i_prg_count,
    output bmsi_pkg::t_job o_job
);
    import bmsi_pkg::*;

    localparam logic [15:0] LINE = 16'(CYCLES_PER_LINE);

    logic [7:0]  r_prg [PRG_SLOTS];
    logic [7:0]  r_chr [CHR_SLOTS];
    logic [15:0] r_counter;
    logic [15:0] r_reload;
    logic        r_enable;
    logic [2:0]  r_mode;
    logic        r_pending;

    logic [7:0]  n_prg [PRG_SLOTS];
    logic [7:0]  n_chr [CHR_SLOTS];
    logic [15:0] n_counter;
    logic [15:0] n_reload;
    logic        n_enable;
    logic [2:0]  n_mode;
    logic        n_pending;

    logic [15:0] a;
    logic [3:0]  page;
    logic [1:0]  prg_idx;
    logic [2:0]  chr_idx;
    logic [15:0] now;
    logic        fire;

    assign a       = i_addr & ADDR_MASK;
    assign page    = a[15:12];
    assign prg_idx = {1'b0, a[1]};
    assign chr_idx = {page[1:0] - 2'd2, a[1]};
    assign now     = r_counter - LINE;

    // Boundary test picked by mode priority; below-threshold always fires
    always_comb begin
        fire = 1'b0;
        if (r_counter < LINE) begin
            fire = 1'b1;
        end else if (r_mode[2]) begin
            fire = now[15:4] != r_counter[15:4];
        end else if (r_mode[1]) begin
            fire = now[15:8] != r_counter[15:8];
        end else if (r_mode[0]) begin
            fire = now[15:12] != r_counter[15:12];
        end
    end

    always_comb begin
        n_prg     = r_prg;
        n_chr     = r_chr;
        n_counter = r_counter;
        n_reload  = r_reload;
        n_enable  = r_enable;
        n_mode    = r_mode;
        n_pending = r_pending;
        o_job     = '{kind: KIND_STATUS, slot: 3'd0, value: 8'd0, irq: 1'b0,
                      reset_seq: 1'b0};
        case (i_op)
            OP_WRITE: begin
                case (page)
                    PAGE_PRG01: begin
                        n_prg[prg_idx] = set_nibble(r_prg[prg_idx], a[0], i_wdata[3:0]);
                        o_job.kind     = KIND_PRG;
                        o_job.slot     = {1'b0, prg_idx};
                        o_job.value    = n_prg[prg_idx];
                    end
                    PAGE_PRG2: begin
                        if (!a[1]) begin
                            n_prg[2]    = set_nibble(r_prg[2], a[0], i_wdata[3:0]);
                            o_job.kind  = KIND_PRG;
                            o_job.slot  = 3'd2;
                            o_job.value = n_prg[2];
                        end
                    end
                    PAGE_IRQ_LATCH: begin
                        case (a[1:0])
                            2'd0:    n_reload[3:0]   = i_wdata[3:0];
                            2'd1:    n_reload[7:4]   = i_wdata[3:0];
                            2'd2:    n_reload[11:8]  = i_wdata[3:0];
                            default: n_reload[15:12] = i_wdata[3:0];
                        endcase
                    end
                    PAGE_IRQ_CTRL: begin
                        case (a[1:0])
                            CTRL_RELOAD: begin
                                n_counter = r_reload;
                                n_pending = 1'b0;
                            end
                            CTRL_ENABLE: begin
                                n_enable  = i_wdata[0];
                                n_mode    = i_wdata[3:1];
                                n_pending = 1'b0;
                            end
                            CTRL_MIRROR: begin
                                o_job.kind  = KIND_MIRROR;
                                o_job.value = {6'd0, i_wdata[1:0]};
                            end
                            default: ;
                        endcase
                    end
                    default: begin
                        if (page >= PAGE_CHR_FIRST && page <= PAGE_CHR_LAST) begin
                            n_chr[chr_idx] = set_nibble(r_chr[chr_idx], a[0], i_wdata[3:0]);
                            o_job.kind     = KIND_CHR;
                            o_job.slot     = chr_idx;
                            o_job.value    = n_chr[chr_idx];
                        end
                    end
                endcase
            end
            OP_TICK: begin
                if (r_enable) begin
                    n_counter = fire ? r_reload : now;
                    if (fire) begin
                        n_pending = 1'b1;
                    end
                end
            end
            OP_RESET: begin
                n_prg[0]  = 8'd0;
                n_prg[1]  = 8'd1;
                n_prg[2]  = i_prg_count - 8'd2;
                for (int i = 0; i < CHR_SLOTS; i++) begin
                    n_chr[i] = 8'd0;
                end
                n_counter = 16'd0;
                n_reload  = 16'd0;
                n_enable  = 1'b0;
                n_mode    = 3'd0;
                n_pending = 1'b0;
                // Back end expands this into the four program windows
                o_job.kind      = KIND_PRG;
                o_job.value     = i_prg_count;
                o_job.reset_seq = 1'b1;
            end
            default: ;
        endcase
        o_job.irq = n_pending;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prg[0]  <= 8'd0;
            r_prg[1]  <= 8'd1;
            r_prg[2]  <= PRG_COUNT_RESET[7:0] - 8'd2;
            for (int i = 0; i < CHR_SLOTS; i++) begin
                r_chr[i] <= 8'd0;
            end
            r_counter <= 16'd0;
            r_reload  <= 16'd0;
            r_enable  <= 1'b0;
            r_mode    <= 3'd0;
            r_pending <= 1'b0;
        end else if (i_accept) begin
            r_prg     <= n_prg;
            r_chr     <= n_chr;
            r_counter <= n_counter;
            r_reload  <= n_reload;
            r_enable  <= n_enable;
            r_mode    <= n_mode;
            r_pending <= n_pending;
        end
    end

endmodule

>>> hdl/bmsi_queue.sv
// Short job queue between the front and back ends of the bank mapper.
// Depends on bmsi_pkg and the assertion macro header.
`include "bank_mapper_with_scanline_irq_defines.svh"

module bmsi_queue #(
    parameter int DEPTH = 4
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  bmsi_pkg::t_job i_job,
    input  logic           i_pop,
    output bmsi_pkg::t_job o_head,
    output logic           o_full,
    output logic           o_empty
);
    import bmsi_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

    t_job             r_slots [DEPTH];
    logic [PTR_W-1:0] r_wr;
    logic [PTR_W-1:0] r_rd;
    logic [CNT_W-1:0] r_count;

    assign o_head  = r_slots[r_rd];
    assign o_full  = r_count == CNT_W'(DEPTH);
    assign o_empty = r_count == '0;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slots[r_wr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == PTR_LAST) ? '0 : r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= (r_rd == PTR_LAST) ? '0 : r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    `BMSI_ASSERT_NOW(a_push_not_full, i_clk, i_rst_n, i_push, !o_full, "push into full job queue")
    `BMSI_ASSERT_NOW(a_pop_not_empty, i_clk, i_rst_n, i_pop, !o_empty, "pop from empty job queue")
    `BMSI_ASSERT_NEXT(a_count_up, i_clk, i_rst_n, i_push && !i_pop, r_count == $past(r_count) + 1'b1, "queue count did not advance on push")
    `BMSI_ASSERT_NEXT(a_count_down, i_clk, i_rst_n, i_pop && !i_push, r_count == $past(r_count) - 1'b1, "queue count did not drop on pop")

endmodule

>>> hdl/bmsi_back.sv
// Back end: expands queued jobs into result items behind an output register.
// Depends on bmsi_pkg and the result channel interface.
module bmsi_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  bmsi_pkg::t_job i_head,
    input  logic           i_empty,
    output logic           o_pop,
    bmsi_out_if.source     o_out
);
    import bmsi_pkg::*;

    logic       r_valid;
    logic [1:0] r_kind;
    logic [2:0] r_slot;
    logic [7:0] r_value;
    logic       r_irq;
    logic       r_last;
    logic [1:0] r_sub;

    logic       load;
    logic       seq_end;
    logic [7:0] seq_value;

    assign load    = !r_valid || o_out.ready;
    assign seq_end = r_sub == PRG_SLOT_LAST;
    assign o_pop   = load && !i_empty && (!i_head.reset_seq || seq_end);

    // Mapper reset windows: 0, 1, count-2, count-1
    always_comb begin
        case (r_sub)
            2'd0:    seq_value = 8'd0;
            2'd1:    seq_value = 8'd1;
            2'd2:    seq_value = i_head.value - 8'd2;
            default: seq_value = i_head.value - 8'd1;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_sub   <= 2'd0;
        end else if (load) begin
            r_valid <= !i_empty;
            if (!i_empty && i_head.reset_seq) begin
                r_sub <= r_sub + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load && !i_empty) begin
            r_kind <= i_head.kind;
            r_irq  <= i_head.irq;
            if (i_head.reset_seq) begin
                r_slot  <= {1'b0, r_sub};
                r_value <= seq_value;
                r_last  <= seq_end;
            end else begin
                r_slot  <= i_head.slot;
                r_value <= i_head.value;
                r_last  <= 1'b1;
            end
        end
    end

    assign o_out.valid    = r_valid;
    assign o_out.kind     = r_kind;
    assign o_out.slot     = r_slot;
    assign o_out.value    = r_value;
    assign o_out.irq_line = r_irq;
    assign o_out.last     = r_last;

endmodule

>>> hdl/bank_mapper_with_scanline_irq.sv
// Top level of the bank mapper with scanline IRQ: front end, job queue, back end, APB port.
// Depends on bmsi_pkg, bmsi_if, bmsi_front, bmsi_queue and bmsi_back.
//
//  port      | direction | handshake        | carries
//  ----------+-----------+------------------+------------------------------------
//  i_in      | in        | valid/ready      | op, addr, wdata
//  o_out     | out       | valid/ready      | kind, slot, value, irq_line, last
//  APB       | in/out    | psel/penable     | prg_bank_count at byte address 0
//
// One request is accepted per cycle while the job queue has room; its first result
// passes through a job queue slot, then the output register, before it is valid.
// A mapper reset request yields four results and holds the back end until the last is out.
// The queue (QUEUE_DEPTH jobs) lets requests keep arriving while o_out is stalled;
// i_in.ready drops only once it is full. i_rst_n is synchronous; no clearing pass.
module bank_mapper_with_scanline_irq #(
    parameter int CYCLES_PER_LINE = 113,
    parameter int QUEUE_DEPTH     = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    bmsi_in_if.sink     i_in,
    bmsi_out_if.source  o_out,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import bmsi_pkg::*;

    logic [8:0] r_prg_count;
    logic       accept;
    logic       full;
    logic       empty;
    logic       pop;
    t_job       job;
    t_job       head;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_PRG_COUNT) ? {23'd0, r_prg_count} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prg_count <= PRG_COUNT_RESET;
        end else if (psel && penable && pwrite && paddr[2] == REG_PRG_COUNT) begin
            r_prg_count <= pwdata[8:0];
        end
    end

    assign i_in.ready = !full;
    assign accept     = i_in.valid && !full;

    bmsi_front #(
        .CYCLES_PER_LINE(CYCLES_PER_LINE)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_op        (i_in.op),
        .i_addr      (i_in.addr),
        .i_wdata     (i_in.wdata),
        .i_prg_count (r_prg_count[7:0]),
        .o_job       (job)
    );

    bmsi_queue #(
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (accept),
        .i_job   (job),
        .i_pop   (pop),
        .o_head  (head),
        .o_full  (full),
        .o_empty (empty)
    );

    bmsi_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (head),
        .i_empty (empty),
        .o_pop   (pop),
        .o_out   (o_out)
    );

endmodule

>>> test/tb_top.sv
`timescale 1ns / 1ps
// Self-checking bench for the bank mapper with scanline IRQ. It drives CPU requests
// and predicts every program, character, mirroring and status result, checked in order.
// Depends on bmsi_pkg, the bmsi_in_if / bmsi_out_if channels and the mapper RTL.
module tb_top;
    import bmsi_pkg::*;

    localparam logic [1:0] OP_UNUSED   = 2'd3;
    localparam int         LINE_CYCLES = 113;
    localparam logic [2:0] COUNT_ADDR  = {REG_PRG_COUNT, 2'b00};

    typedef struct packed {
        logic [1:0]  op;
        logic [15:0] addr;
        logic [7:0]  wdata;
    } t_cpu_req;

    typedef struct packed {
        logic [1:0] kind;
        logic [2:0] slot;
        logic [7:0] value;
        logic       irq;
        logic       last;
    } t_map_result;

    logic        i_clk;
    logic        i_rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    bmsi_in_if  req_if();
    bmsi_out_if res_if();

    bank_mapper_with_scanline_irq dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (req_if),
        .o_out   (res_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Mapper state as the block should hold it
    logic [8:0]  prg_count;
    logic [7:0]  prg_bank [PRG_SLOTS];
    logic [7:0]  chr_bank [CHR_SLOTS];
    logic [15:0] line_counter;
    logic [15:0] counter_reload;
    logic        irq_on;
    logic [2:0]  width_mode;
    logic        irq_flag;

    t_cpu_req    pending_reqs[$];
    t_map_result due_results[$];

    int  errors;
    int  items_queued;
    int  items_taken;
    int  results_checked;
    int  irq_raises;
    int  mapper_resets;
    int  settings_used;
    int  send_gap;
    int  stall_left;
    bit  req_taken;
    bit  calm;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Watchdog
    initial begin
        #5_000_000;
        $display("TB_ERROR");
        $finish;
    end

    task automatic flag_mismatch(input string msg);
        $display("mismatch at %0t: %s", $time, msg);
        errors++;
    endtask

    function automatic logic [7:0] with_nibble(logic [7:0] old, logic hi, logic [3:0] v);
        return hi ? {v, old[3:0]} : {old[7:4], v};
    endfunction

    function automatic void clear_mapper();
        int i;
        prg_bank[0] = 8'd0;
        prg_bank[1] = 8'd1;
        prg_bank[2] = 8'(prg_count - 9'd2);
        for (i = 0; i < CHR_SLOTS; i++) chr_bank[i] = 8'd0;
        line_counter   = 16'd0;
        counter_reload = 16'd0;
        irq_on         = 1'b0;
        width_mode     = 3'd0;
        irq_flag       = 1'b0;
    endfunction

    function automatic void due_result(logic [1:0] kind, logic [2:0] slot, logic [7:0] value);
        due_results.push_back('{kind, slot, value, irq_flag, 1'b0});
    endfunction

    function automatic void scanline_tick();
        logic [15:0] was;
        logic [15:0] now;
        logic        fire;
        if (irq_on) begin
            was  = line_counter;
            fire = 1'b0;
            if (was < LINE_CYCLES) begin
                fire = 1'b1;
            end else begin
                now = was - 16'(LINE_CYCLES);
                line_counter = now;
                // highest mode bit wins: 4-bit, then 8-bit, then 12-bit boundary
                if (width_mode[2]) fire = now[15:4] != was[15:4];
                else if (width_mode[1]) fire = now[15:8] != was[15:8];
                else if (width_mode[0]) fire = now[15:12] != was[15:12];
            end
            if (fire) begin
                line_counter = counter_reload;
                irq_flag = 1'b1;
                irq_raises++;
            end
        end
    endfunction

    function automatic void mapper_step(t_cpu_req r);
        logic [15:0] a;
        logic [3:0]  page;
        logic [2:0]  s;
        t_map_result tail;
        int          i;
        a    = r.addr & ADDR_MASK;
        page = a[15:12];
        case (r.op)
            OP_WRITE: begin
                if (page == PAGE_PRG01 || (page == PAGE_PRG2 && !a[1])) begin
                    s = (page == PAGE_PRG2) ? 3'd2 : {2'b00, a[1]};
                    prg_bank[s] = with_nibble(prg_bank[s], a[0], r.wdata[3:0]);
                    due_result(KIND_PRG, s, prg_bank[s]);
                end else if (page >= PAGE_CHR_FIRST && page <= PAGE_CHR_LAST) begin
                    s = {2'(page - PAGE_CHR_FIRST), a[1]};
                    chr_bank[s] = with_nibble(chr_bank[s], a[0], r.wdata[3:0]);
                    due_result(KIND_CHR, s, chr_bank[s]);
                end else if (page == PAGE_IRQ_LATCH) begin
                    counter_reload[{a[1:0], 2'b00} +: 4] = r.wdata[3:0];
                    due_result(KIND_STATUS, 3'd0, 8'd0);
                end else if (page == PAGE_IRQ_CTRL && a[1:0] == CTRL_MIRROR) begin
                    due_result(KIND_MIRROR, 3'd0, {6'd0, r.wdata[1:0]});
                end else begin
                    if (page == PAGE_IRQ_CTRL && a[1:0] == CTRL_RELOAD) begin
                        line_counter = counter_reload;
                        irq_flag = 1'b0;
                    end
                    if (page == PAGE_IRQ_CTRL && a[1:0] == CTRL_ENABLE) begin
                        irq_on     = r.wdata[0];
                        width_mode = r.wdata[3:1];
                        irq_flag   = 1'b0;
                    end
                    due_result(KIND_STATUS, 3'd0, 8'd0);
                end
            end
            OP_TICK: begin
                scanline_tick();
                due_result(KIND_STATUS, 3'd0, 8'd0);
            end
            OP_RESET: begin
                clear_mapper();
                mapper_resets++;
                for (i = 0; i < PRG_SLOTS; i++) due_result(KIND_PRG, 3'(i), prg_bank[i]);
                due_result(KIND_PRG, {1'b0, PRG_SLOT_LAST}, 8'(prg_count - 9'd1));
            end
            default: due_result(KIND_STATUS, 3'd0, 8'd0);
        endcase
        tail = due_results.pop_back();
        tail.last = 1'b1;
        due_results.push_back(tail);
    endfunction

    function automatic void add_req(logic [1:0] op, logic [15:0] addr, logic [7:0] wdata);
        pending_reqs.push_back('{op, addr, wdata});
        items_queued++;
    endfunction

    // Bits 11:2 are outside the decode mask, so fill them with noise
    function automatic logic [15:0] with_free_bits(logic [3:0] page, logic [1:0] low);
        logic [11:0] junk;
        junk = 12'($urandom);
        return {page, junk[11:2], low};
    endfunction

    function automatic int idle_span();
        int r;
        if (calm) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic void add_directed();
        add_req(OP_RESET, 16'h0000, 8'h00);
        add_req(OP_WRITE, with_free_bits(PAGE_PRG01, 2'd0), 8'hFF);
        add_req(OP_WRITE, with_free_bits(PAGE_PRG01, 2'd1), 8'hA5);
        add_req(OP_WRITE, with_free_bits(PAGE_PRG01, 2'd3), 8'hFF);
        add_req(OP_WRITE, with_free_bits(PAGE_PRG2, 2'd0), 8'h00);
        add_req(OP_WRITE, with_free_bits(PAGE_PRG2, 2'd1), 8'hFF);
        add_req(OP_WRITE, with_free_bits(PAGE_PRG2, 2'd2), 8'h12);
        add_req(OP_WRITE, with_free_bits(PAGE_CHR_FIRST, 2'd0), 8'h0F);
        add_req(OP_WRITE, with_free_bits(PAGE_CHR_LAST, 2'd3), 8'hFF);
        // reload value 0x0100
        add_req(OP_WRITE, with_free_bits(PAGE_IRQ_LATCH, 2'd0), 8'hF0);
        add_req(OP_WRITE, with_free_bits(PAGE_IRQ_LATCH, 2'd1), 8'h00);
        add_req(OP_WRITE, with_free_bits(PAGE_IRQ_LATCH, 2'd2), 8'h01);
        add_req(OP_WRITE, with_free_bits(PAGE_IRQ_LATCH, 2'd3), 8'h00);
        add_req(OP_WRITE, with_free_bits(PAGE_IRQ_CTRL, CTRL_RELOAD), 8'h00);
        // enabled, all mode bits: the 4-bit boundary has priority
        add_req(OP_WRITE, with_free_bits(PAGE_IRQ_CTRL, CTRL_ENABLE), 8'h0F);
        add_req(OP_TICK, 16'hFFFF, 8'hFF);
        // mode 0: only the below-threshold test can fire, and neither tick starts below it
        add_req(OP_WRITE, with_free_bits(PAGE_IRQ_CTRL, CTRL_ENABLE), 8'h01);
        add_req(OP_TICK, 16'h0000, 8'h00);
        add_req(OP_TICK, 16'h0000, 8'h00);
        add_req(OP_WRITE, with_free_bits(PAGE_IRQ_CTRL, CTRL_MIRROR), 8'hFE);
        add_req(OP_WRITE, with_free_bits(PAGE_IRQ_CTRL, 2'd3), 8'h00);
        add_req(OP_UNUSED, 16'hFFFF, 8'hFF);
        add_req(OP_WRITE, 16'h7FFF, 8'hFF);
        add_req(OP_WRITE, with_free_bits(PAGE_IRQ_CTRL, CTRL_ENABLE), 8'h00);
        add_req(OP_TICK, 16'h0000, 8'h00);
    endfunction

    // Latch a reload value, mostly reload and enable the counter, then run a burst of scanlines
    function automatic void add_irq_program();
        logic [15:0] reload;
        int          pick;
        int          n;
        int          i;
        pick = $urandom_range(0, 9);
        if (pick < 4) reload = 16'($urandom_range(0, 400));
        else if (pick < 7)
            reload = {4'($urandom_range(1, 15)), 12'd0} + 16'($urandom_range(0, 300));
        else reload = 16'($urandom);
        for (i = 0; i < 4; i++) begin
            add_req(OP_WRITE, with_free_bits(PAGE_IRQ_LATCH, 2'(i)),
                    {4'($urandom), reload[4*i +: 4]});
        end
        if ($urandom_range(0, 9) != 0)
            add_req(OP_WRITE, with_free_bits(PAGE_IRQ_CTRL, CTRL_RELOAD), 8'($urandom));
        add_req(OP_WRITE, with_free_bits(PAGE_IRQ_CTRL, CTRL_ENABLE),
                {4'($urandom), 3'($urandom), 1'($urandom_range(0, 7) != 0)});
        n = $urandom_range(1, 10);
        for (i = 0; i < n; i++) add_req(OP_TICK, 16'($urandom), 8'($urandom));
    endfunction

    function automatic void add_random_phase(int n);
        int start;
        int pick;
        start = items_queued;
        add_req(OP_RESET, 16'($urandom), 8'($urandom));
        while (items_queued - start < n) begin
            pick = $urandom_range(0, 99);
            if (pick < 30) add_irq_program();
            else if (pick < 55)
                add_req(OP_WRITE, with_free_bits(4'($urandom_range(8, 13)), 2'($urandom)),
                        8'($urandom));
            else if (pick < 66) add_req(OP_TICK, 16'($urandom), 8'($urandom));
            else if (pick < 73)
                add_req(OP_WRITE, with_free_bits(PAGE_IRQ_CTRL, CTRL_MIRROR), 8'($urandom));
            else if (pick < 79) add_req(OP_RESET, 16'($urandom), 8'($urandom));
            else if (pick < 87) add_req(OP_WRITE, 16'($urandom), 8'($urandom));
            else if (pick < 92) add_req(OP_UNUSED, 16'($urandom), 8'($urandom));
            else add_req(OP_WRITE, with_free_bits(PAGE_IRQ_CTRL, 2'($urandom)), 8'($urandom));
        end
    endfunction

    // Hold until every request is in and every result is out, then let the pipe settle
    task automatic wait_idle();
        while (pending_reqs.size() != 0 || req_if.valid || due_results.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_bank_count(input logic [8:0] cnt);
        logic [31:0] rd;
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= COUNT_ADDR;
        pwdata  <= {23'd0, cnt};
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        rd = prdata;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (rd[8:0] !== cnt)
            flag_mismatch($sformatf("bank count reads %0d, wrote %0d", rd[8:0], cnt));
        prg_count = cnt;
        settings_used++;
    endtask

    // Driver: requests and result back-pressure change on the falling edge
    always @(negedge i_clk) begin
        t_cpu_req nxt;
        if (!i_rst_n) begin
            req_if.valid <= 1'b0;
            res_if.ready <= 1'b0;
        end else begin
            if (!req_if.valid || req_taken) begin
                if (send_gap > 0) begin
                    send_gap--;
                    req_if.valid <= 1'b0;
                end else if (pending_reqs.size() > 0) begin
                    nxt = pending_reqs.pop_front();
                    req_if.valid <= 1'b1;
                    req_if.op    <= nxt.op;
                    req_if.addr  <= nxt.addr;
                    req_if.wdata <= nxt.wdata;
                    send_gap = idle_span();
                end else begin
                    req_if.valid <= 1'b0;
                end
            end
            if (stall_left > 0) begin
                stall_left--;
                res_if.ready <= 1'b0;
            end else begin
                res_if.ready <= 1'b1;
                stall_left = idle_span();
            end
        end
    end

    // Monitor: predict on each accepted request, check each accepted result
    always @(posedge i_clk) begin
        t_map_result got;
        t_map_result want;
        if (!i_rst_n) begin
            req_taken = 1'b0;
        end else begin
            req_taken = req_if.valid && req_if.ready;
            if (req_taken) begin
                mapper_step('{req_if.op, req_if.addr, req_if.wdata});
                items_taken++;
            end
            if (res_if.valid && res_if.ready) begin
                got = '{res_if.kind, res_if.slot, res_if.value, res_if.irq_line, res_if.last};
                if (due_results.size() == 0) begin
                    flag_mismatch($sformatf("unexpected result kind %0d slot %0d value %02h",
                                            got.kind, got.slot, got.value));
                end else begin
                    want = due_results.pop_front();
                    results_checked++;
                    if (got !== want)
                        flag_mismatch($sformatf(
                            {"got kind %0d slot %0d value %02h irq %0b last %0b, ",
                             "want %0d %0d %02h %0b %0b"},
                            got.kind, got.slot, got.value, got.irq, got.last,
                            want.kind, want.slot, want.value, want.irq, want.last));
                end
            end
        end
    end

    initial begin
        i_rst_n      = 1'b0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        req_if.valid = 1'b0;
        req_if.op    = OP_WRITE;
        req_if.addr  = '0;
        req_if.wdata = '0;
        res_if.ready = 1'b0;
        calm         = 1'b0;
        send_gap     = 0;
        stall_left   = 0;
        prg_count    = PRG_COUNT_RESET;
        clear_mapper();
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;

        add_directed();
        wait_idle();
        write_bank_count(9'd2);
        add_random_phase(30);
        wait_idle();
        // count of 256, and no idling on either side for this stretch
        write_bank_count(9'd256);
        calm = 1'b1;
        add_random_phase(30);
        wait_idle();
        calm = 1'b0;
        write_bank_count(9'($urandom_range(3, 255)));
        add_random_phase(30);
        wait_idle();
        write_bank_count(PRG_COUNT_RESET);
        add_random_phase(30);
        wait_idle();
        repeat (8) @(posedge i_clk);

        $display("covered %0d requests, %0d results checked, %0d bank-count settings",
                 items_taken, results_checked, settings_used + 1);
        $display("scanline IRQ raised %0d times, %0d mapper resets, %0d mismatches",
                 irq_raises, mapper_resets, errors);
        if (errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
